@@ design/rms_pkg.sv @@
// Shared types and widths for the record merge sorter.
package rms_pkg;

    localparam int KEY_W   = 16;
    localparam int TAG_W   = 8;
    localparam int REC_W   = KEY_W + TAG_W;
    localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

    // Key in the low bits, tag above it, same as the tdata layout.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_rec;

endpackage

@@ design/record_merge_sorter_top.sv @@
// Record merge sorter: loads a set of keyed records, sorts them (stably when ascending), streams them out.
// Load: records are accepted back to back; the block is ready for input only while loading.
// Sort: bottom-up merge over ceil(log2 n) passes; each merged record is read (S_MRD), then compared
//   and written (S_MCMP) on the shared two-read, one-write record memory and the single key comparator;
//   each merge run and each pass end go through S_PASS.
// Emit: each record goes through read, load and hand over (S_ERD, S_ELD, S_OUT), held until m_axis_tready.
// Reset (synchronous, active low) empties the store, clears the drop flag and the descending
//   register, and returns to loading; memory contents are not cleared.
module record_merge_sorter_top #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: descending register, written whenever i_cfg_we is high
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    // Input records
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rms_pkg::TDATA_W-1:0] s_axis_tdata,  // [15:0] sort_key, [23:16] record_tag
    input  logic                        s_axis_tlast,  // is_final
    // Sorted records
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rms_pkg::TDATA_W-1:0] m_axis_tdata,  // [15:0] out_key, [23:16] out_tag
    output logic                        m_axis_tlast,  // out_final
    output logic                        m_axis_tuser   // overflowed
);
    import rms_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // index into one bank
    localparam int CW    = $clog2(CAPACITY + 1);                    // count up to CAPACITY
    localparam int PW    = CW + 2;                                  // pointers, lo + 2*width
    localparam int BANK  = 1 << AW;
    localparam int MEM_D = 2 * BANK;

    typedef enum logic [2:0] {
        S_LOAD,   // accept records into bank 0
        S_PASS,   // set up the next merge run or finish a pass
        S_MRD,    // read heads of both runs
        S_MCMP,   // compare heads, write winner to the other bank
        S_ERD,    // read record for the next output position
        S_ELD,    // load output register
        S_OUT     // hold output until taken
    } t_state;

    t_state r_state;

    // Two banks of records; a merge pass reads one bank and writes the other.
    t_rec   r_mem [MEM_D];
    t_rec   r_rd_a;
    t_rec   r_rd_b;

    logic          r_desc;
    logic [CW-1:0] r_fill;
    logic          r_drop;
    logic          r_ovf;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_k;
    logic          r_src;
    logic [PW-1:0] r_width;
    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_a;
    logic [PW-1:0] r_b;
    logic [PW-1:0] r_mid;
    logic [PW-1:0] r_hi;
    logic [PW-1:0] r_wp;

    t_rec          r_out;
    logic          r_out_valid;
    logic          r_out_last;

    // Datapath signals
    t_rec          in_rec;
    logic          in_acc;
    logic          has_room;
    logic [CW-1:0] n_fill;
    logic [PW-1:0] n_ext;
    logic [PW-1:0] mid_raw;
    logic [PW-1:0] hi_raw;
    logic [PW-1:0] width2;
    logic          take_a;
    logic [CW-1:0] emit_idx;
    logic [AW:0]   rd_addr_a;
    logic [AW:0]   rd_addr_b;
    logic          wr_en;
    logic [AW:0]   wr_addr;
    t_rec          wr_data;

    assign in_rec   = t_rec'(s_axis_tdata[REC_W-1:0]);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign has_room = (r_fill < CW'(CAPACITY));
    assign n_fill   = has_room ? r_fill + CW'(1) : r_fill;

    assign n_ext   = PW'(r_n);
    assign mid_raw = r_lo + r_width;
    assign width2  = r_width << 1;
    assign hi_raw  = r_lo + width2;

    // Stable: a tie takes the left run.
    assign take_a = (r_a < r_mid) && ((r_b >= r_hi) || (r_rd_a.key <= r_rd_b.key));

    assign emit_idx = r_desc ? (r_n - CW'(1) - r_k) : r_k;

    always_comb begin
        if (r_state == S_ERD) begin
            rd_addr_a = {r_src, emit_idx[AW-1:0]};
        end else begin
            rd_addr_a = {r_src, r_a[AW-1:0]};
        end
    end
    assign rd_addr_b = {r_src, r_b[AW-1:0]};

    // Single write port: loading into bank 0, merging into the opposite bank.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {1'b0, r_fill[AW-1:0]};
        wr_data = in_rec;
        if (r_state == S_LOAD) begin
            wr_en = in_acc && has_room;
        end else if (r_state == S_MCMP) begin
            wr_en   = 1'b1;
            wr_addr = {~r_src, r_wp[AW-1:0]};
            wr_data = take_a ? r_rd_a : r_rd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg_we) begin
            r_desc <= i_cfg_wdata;
        end
    end

    // Sequencer: load, merge passes, emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_ovf       <= 1'b0;
            r_src       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_n         <= '0;
            r_k         <= '0;
            r_width     <= '0;
            r_lo        <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_fill <= n_fill;
                        if (s_axis_tlast) begin
                            // Latch the run size and drop status; first pass if n > 1, else emit.
                            r_n     <= n_fill;
                            r_ovf   <= r_drop || !has_room;
                            r_drop  <= 1'b0;
                            r_width <= PW'(1);
                            r_lo    <= '0;
                            r_k     <= '0;
                            r_src   <= 1'b0;
                            r_state <= (n_fill <= CW'(1)) ? S_ERD : S_PASS;
                        end else if (!has_room) begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_PASS: begin
                    if (r_lo >= n_ext) begin
                        // Pass done: swap banks, double the run width.
                        r_src   <= ~r_src;
                        r_width <= width2;
                        r_lo    <= '0;
                        r_state <= (width2 >= n_ext) ? S_ERD : S_PASS;
                    end else begin
                        // A run with an empty right half is a plain copy.
                        r_a     <= r_lo;
                        r_wp    <= r_lo;
                        r_mid   <= (mid_raw < n_ext) ? mid_raw : n_ext;
                        r_b     <= (mid_raw < n_ext) ? mid_raw : n_ext;
                        r_hi    <= (hi_raw < n_ext) ? hi_raw : n_ext;
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MCMP;
                end
                S_MCMP: begin
                    if (take_a) begin
                        r_a <= r_a + PW'(1);
                    end else begin
                        r_b <= r_b + PW'(1);
                    end
                    r_wp <= r_wp + PW'(1);
                    if (r_wp + PW'(1) == r_hi) begin
                        r_lo    <= hi_raw;
                        r_state <= S_PASS;
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    r_out       <= r_rd_a;
                    r_out_last  <= (r_k + CW'(1) == r_n);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            // Run complete: empty the store.
                            r_fill  <= '0;
                            r_src   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_ovf;

endmodule

@@ design/rms_checker.sv @@
// Port-level checker for the record merge sorter, bound to the top level.
module rms_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [rms_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                        m_axis_tlast
);
    import rms_pkg::*;

    // Hold a stalled output transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    // Never take input while results are pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while output valid");

    // Return to loading after the final result of a run.
    a_last_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("no return to loading after final result");

    // Reset drops output and opens the input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset state wrong");

endmodule

bind record_merge_sorter_top rms_checker u_rms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
